// ----- rtl/core/vcbt_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// vcbt_pkg
// Types and constants shared by the vector clock bound tracker core.
// ---------------------------------------------------------------------------
package vcbt_pkg;

   localparam int VALUE_W = 32;
   localparam int SLOT_W  = 3;
   localparam int ID_W    = 3;
   localparam int COUNT_W = 4;
   localparam int LEADER_W = 4;

   localparam logic signed [VALUE_W-1:0] INT_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
   localparam logic signed [VALUE_W-1:0] INT_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
   localparam logic [LEADER_W-1:0]       LEADER_NONE = {LEADER_W{1'b1}};

   typedef enum logic {
      REQ_COMPONENT = 1'b0,
      REQ_CLEAR     = 1'b1
   } req_kind_type;

   // One input item as held in the input register.
   typedef struct packed {
      req_kind_type               kind;
      logic [ID_W-1:0]            sender;
      logic [SLOT_W-1:0]          slot;
      logic signed [VALUE_W-1:0]  value;
   } item_type;

   // One result item as held in the result register.
   typedef struct packed {
      logic [SLOT_W-1:0]          slot;
      logic signed [VALUE_W-1:0]  upper;
      logic signed [VALUE_W-1:0]  lower;
      logic [LEADER_W-1:0]        leader;
      logic [COUNT_W-1:0]         count;
      logic                       done;
   } result_type;

endpackage
`default_nettype wire

// ----- rtl/core/vector_clock_bound_tracker_core.sv -----
`default_nettype none
// An accepted item goes from the input register to the result register,
// which drives rsp_valid. Throughput: one item per cycle while the result
// register is empty or being drained; the input register feeds a single
// compare and update stage that writes bound stores and result register.
// Reset clears all bounds, leaders, the seen map, the count and alive_count.
// ---------------------------------------------------------------------------
// vector_clock_bound_tracker_core
// Keeps per-slot maximum and minimum of vector clock components over a sync
// round, the first server that supplied each maximum, and a count of the
// distinct senders seen. A clear item starts a new round.
// ---------------------------------------------------------------------------
module vector_clock_bound_tracker_core
   import vcbt_pkg::*;
#(
   parameter int SERVERS = 8
) (
   input  wire logic                       clock,
   input  wire logic                       reset,

   input  wire logic                       req_valid,
   output      logic                       req_ready,
   input  wire logic                       req_type,
   input  wire logic [ID_W-1:0]            req_sender,
   input  wire logic [SLOT_W-1:0]          req_slot,
   input  wire logic signed [VALUE_W-1:0]  req_value,

   output      logic                       rsp_valid,
   input  wire logic                       rsp_ready,
   output      logic [SLOT_W-1:0]          rsp_out_slot,
   output      logic signed [VALUE_W-1:0]  rsp_upper,
   output      logic signed [VALUE_W-1:0]  rsp_lower,
   output      logic signed [LEADER_W-1:0] rsp_leader,
   output      logic [COUNT_W-1:0]         rsp_received_count,
   output      logic                       rsp_round_done,

   input  wire logic                       csr_we,
   input  wire logic [COUNT_W-1:0]         csr_wdata
);

   // Sender and slot fields are three bits wide, so at most eight entries
   // can ever be addressed regardless of the server count.
   localparam int ENTRIES = (SERVERS < (1 << ID_W)) ? SERVERS : (1 << ID_W);
   localparam int IDX_W   = $clog2(ENTRIES);
   localparam logic [ID_W:0] ENTRIES_W = (ID_W+1)'(ENTRIES);

   logic                       s1_valid_ff;
   item_type                   s1_ff;
   logic                       s1_advance;

   logic                       out_valid_ff;
   result_type                 out_ff;
   result_type                 out_in;

   logic [COUNT_W-1:0]         alive_ff;

   logic signed [VALUE_W-1:0]  upper_ff  [ENTRIES];
   logic signed [VALUE_W-1:0]  lower_ff  [ENTRIES];
   logic [LEADER_W-1:0]        leader_ff [ENTRIES];
   logic [ENTRIES-1:0]         seen_ff;
   logic [COUNT_W-1:0]         count_ff;

   logic                       is_clear;
   logic                       sender_ok;
   logic                       slot_ok;
   logic [IDX_W-1:0]           sidx;
   logic [IDX_W-1:0]           widx;
   logic                       new_sender;
   logic [COUNT_W-1:0]         count_in;
   logic                       update;
   logic signed [VALUE_W-1:0]  cur_upper;
   logic signed [VALUE_W-1:0]  cur_lower;
   logic [LEADER_W-1:0]        cur_leader;
   logic                       raise;
   logic                       drop;
   logic signed [VALUE_W-1:0]  upper_in;
   logic signed [VALUE_W-1:0]  lower_in;
   logic [LEADER_W-1:0]        leader_in;
   logic                       fire;

   // Handshake: the input register moves on whenever the result register
   // is empty or being drained this cycle.
   assign s1_advance = !out_valid_ff || rsp_ready;
   assign req_ready  = !s1_valid_ff || s1_advance;
   assign fire       = s1_valid_ff && s1_advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_ff.kind   <= req_kind_type'(req_type);
         s1_ff.sender <= req_sender;
         s1_ff.slot   <= req_slot;
         s1_ff.value  <= req_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alive_ff <= '0;
      end else if (csr_we) begin
         alive_ff <= csr_wdata;
      end
   end

   // Compare and update for the item in the input register.
   always_comb begin
      is_clear   = (s1_ff.kind == REQ_CLEAR);
      sender_ok  = {1'b0, s1_ff.sender} < ENTRIES_W;
      slot_ok    = {1'b0, s1_ff.slot} < ENTRIES_W;
      sidx       = s1_ff.sender[IDX_W-1:0];
      widx       = s1_ff.slot[IDX_W-1:0];
      new_sender = sender_ok && !seen_ff[sidx];
      count_in   = count_ff + COUNT_W'(new_sender);
      // Slot zero is not a component: its entry never changes.
      update     = sender_ok && slot_ok && (s1_ff.slot != '0);

      if (slot_ok) begin
         cur_upper  = upper_ff[widx];
         cur_lower  = lower_ff[widx];
         cur_leader = leader_ff[widx];
      end else begin
         cur_upper  = INT_MIN;
         cur_lower  = INT_MAX;
         cur_leader = LEADER_NONE;
      end

      raise     = update && (s1_ff.value > cur_upper);
      drop      = update && (s1_ff.value < cur_lower);
      upper_in  = raise ? s1_ff.value : cur_upper;
      lower_in  = drop  ? s1_ff.value : cur_lower;
      leader_in = raise ? {1'b0, s1_ff.sender} : cur_leader;

      if (is_clear) begin
         out_in.slot   = '0;
         out_in.upper  = INT_MIN;
         out_in.lower  = INT_MAX;
         out_in.leader = LEADER_NONE;
         out_in.count  = '0;
         out_in.done   = (alive_ff == '0);
      end else begin
         out_in.slot   = s1_ff.slot;
         out_in.upper  = upper_in;
         out_in.lower  = lower_in;
         out_in.leader = leader_in;
         out_in.count  = count_in;
         out_in.done   = (count_in == alive_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            upper_ff[i]  <= INT_MIN;
            lower_ff[i]  <= INT_MAX;
            leader_ff[i] <= LEADER_NONE;
         end
         seen_ff  <= '0;
         count_ff <= '0;
      end else if (fire) begin
         if (is_clear) begin
            for (int i = 0; i < ENTRIES; i++) begin
               upper_ff[i]  <= INT_MIN;
               lower_ff[i]  <= INT_MAX;
               leader_ff[i] <= LEADER_NONE;
            end
            seen_ff  <= '0;
            count_ff <= '0;
         end else begin
            if (sender_ok) begin
               seen_ff[sidx] <= 1'b1;
            end
            count_ff <= count_in;
            if (update) begin
               upper_ff[widx]  <= upper_in;
               lower_ff[widx]  <= lower_in;
               leader_ff[widx] <= leader_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s1_advance) begin
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_out_slot       = out_ff.slot;
   assign rsp_upper          = out_ff.upper;
   assign rsp_lower          = out_ff.lower;
   assign rsp_leader         = out_ff.leader;
   assign rsp_received_count = out_ff.count;
   assign rsp_round_done     = out_ff.done;

   // The count always matches the number of marked senders.
   a_count_matches_map : assert property (@(posedge clock) disable iff (reset)
      $countones(seen_ff) == 32'(count_ff))
      else $error("sender count differs from seen map");

   // A clear item leaves an empty round behind it.
   a_clear_empties : assert property (@(posedge clock) disable iff (reset)
      fire && is_clear |=> (count_ff == '0) && (seen_ff == '0))
      else $error("clear item did not empty the round");

   // The result register only loads when an item leaves the input register.
   a_out_loads_on_fire : assert property (@(posedge clock) disable iff (reset)
      !fire && !rsp_ready |=> $stable(out_ff))
      else $error("result register changed without an item");

   for (genvar g = 0; g < ENTRIES; g++) begin : g_entry_chk
      // A slot has a leader exactly when its maximum has risen.
      a_leader_iff_raised : assert property (@(posedge clock) disable iff (reset)
         (leader_ff[g] == LEADER_NONE) == (upper_ff[g] == INT_MIN))
         else $error("leader and maximum disagree");

      a_bounds_ordered : assert property (@(posedge clock) disable iff (reset)
         (leader_ff[g] != LEADER_NONE) |-> (lower_ff[g] <= upper_ff[g]))
         else $error("minimum above maximum");
   end

endmodule
`default_nettype wire
